/* hw/rtl/kfts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Package for the two-state Kalman filter unit
// Shared types, register indexes, operand slots and the update microprogram.
// ----------------------------------------------------------------------------
package kfts_pkg;

   // Fixed-point word width (Q16.16).
   localparam int DW = 32;

   // Microprogram counter width and the address of the final instruction.
   localparam int                PC_W      = 7;
   localparam logic [PC_W-1:0]   PROG_LAST = 7'd78;

   // Configuration register indexes.
   localparam logic [2:0] REG_TRANS_00   = 3'd0;
   localparam logic [2:0] REG_TRANS_01   = 3'd1;
   localparam logic [2:0] REG_TRANS_10   = 3'd2;
   localparam logic [2:0] REG_TRANS_11   = 3'd3;
   localparam logic [2:0] REG_MEAS_ROW_0 = 3'd4;
   localparam logic [2:0] REG_MEAS_ROW_1 = 3'd5;
   localparam logic [2:0] REG_PROC_NOISE = 3'd6;
   localparam logic [2:0] REG_MEAS_NOISE = 3'd7;

   // Microinstruction operations.
   typedef enum logic [3:0] {
      OP_LOAD  = 4'd0,   // acc = value a
      OP_ADDV  = 4'd1,   // acc = acc + value a
      OP_SUBV  = 4'd2,   // acc = acc - value a
      OP_MUL   = 4'd3,   // acc = a * b (Q16.16, rounded, saturated)
      OP_MAC   = 4'd4,   // acc = acc + a * b
      OP_MSUB  = 4'd5,   // acc = acc - a * b
      OP_STORE = 4'd6,   // slot a = saturated acc
      OP_DIVK  = 4'd7,   // slot b = gain from slot a over S
      OP_END   = 4'd8    // count the step and finish
   } op_type;

   // Operand and destination slots of the datapath.
   localparam int NSLOT = 34;
   typedef enum logic [5:0] {
      SL_F0, SL_F1, SL_F2, SL_F3, SL_H0, SL_H1, SL_Q, SL_R, SL_MEAS,
      SL_E0, SL_E1, SL_C0, SL_C1, SL_C2, SL_C3,
      SL_XP0, SL_XP1, SL_FP0, SL_FP1, SL_FP2, SL_FP3,
      SL_PP0, SL_PP1, SL_PP2, SL_PP3, SL_PH0, SL_PH1, SL_S,
      SL_K0, SL_K1, SL_HX, SL_INN, SL_HP0, SL_HP1
   } slot_type;

   typedef struct packed {
      op_type   op;
      slot_type a;
      slot_type b;
   } instr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      req_load;
      logic      init_load;
      instr_type instr;
      logic      exec_en;
      logic      mul_en;
      logic      acc_en;
      logic      div_start;
      logic      div_store;
      logic      step_inc;
      logic      out_load;
      logic      out_nr;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic initialized;
      logic div_busy;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic instr_type mk(op_type o, slot_type a, slot_type b);
      instr_type r;
      r.op = o;
      r.a  = a;
      r.b  = b;
      return r;
   endfunction

   // Update microprogram: predict, gain, correct.
   function automatic instr_type prog_rom(logic [PC_W-1:0] pc);
      instr_type r;
      unique case (pc)
         // Predicted state.
         7'd0:  r = mk(OP_MUL,   SL_F0,  SL_E0);
         7'd1:  r = mk(OP_MAC,   SL_F1,  SL_E1);
         7'd2:  r = mk(OP_STORE, SL_XP0, SL_XP0);
         7'd3:  r = mk(OP_MUL,   SL_F2,  SL_E0);
         7'd4:  r = mk(OP_MAC,   SL_F3,  SL_E1);
         7'd5:  r = mk(OP_STORE, SL_XP1, SL_XP1);
         // F times P.
         7'd6:  r = mk(OP_MUL,   SL_F0,  SL_C0);
         7'd7:  r = mk(OP_MAC,   SL_F1,  SL_C2);
         7'd8:  r = mk(OP_STORE, SL_FP0, SL_FP0);
         7'd9:  r = mk(OP_MUL,   SL_F0,  SL_C1);
         7'd10: r = mk(OP_MAC,   SL_F1,  SL_C3);
         7'd11: r = mk(OP_STORE, SL_FP1, SL_FP1);
         7'd12: r = mk(OP_MUL,   SL_F2,  SL_C0);
         7'd13: r = mk(OP_MAC,   SL_F3,  SL_C2);
         7'd14: r = mk(OP_STORE, SL_FP2, SL_FP2);
         7'd15: r = mk(OP_MUL,   SL_F2,  SL_C1);
         7'd16: r = mk(OP_MAC,   SL_F3,  SL_C3);
         7'd17: r = mk(OP_STORE, SL_FP3, SL_FP3);
         // (F P) times F transposed.
         7'd18: r = mk(OP_MUL,   SL_FP0, SL_F0);
         7'd19: r = mk(OP_MAC,   SL_FP1, SL_F1);
         7'd20: r = mk(OP_STORE, SL_PP0, SL_PP0);
         7'd21: r = mk(OP_MUL,   SL_FP0, SL_F2);
         7'd22: r = mk(OP_MAC,   SL_FP1, SL_F3);
         7'd23: r = mk(OP_STORE, SL_PP1, SL_PP1);
         7'd24: r = mk(OP_MUL,   SL_FP2, SL_F0);
         7'd25: r = mk(OP_MAC,   SL_FP3, SL_F1);
         7'd26: r = mk(OP_STORE, SL_PP2, SL_PP2);
         7'd27: r = mk(OP_MUL,   SL_FP2, SL_F2);
         7'd28: r = mk(OP_MAC,   SL_FP3, SL_F3);
         7'd29: r = mk(OP_STORE, SL_PP3, SL_PP3);
         // Process noise on the diagonal.
         7'd30: r = mk(OP_LOAD,  SL_PP0, SL_PP0);
         7'd31: r = mk(OP_ADDV,  SL_Q,   SL_Q);
         7'd32: r = mk(OP_STORE, SL_PP0, SL_PP0);
         7'd33: r = mk(OP_LOAD,  SL_PP3, SL_PP3);
         7'd34: r = mk(OP_ADDV,  SL_Q,   SL_Q);
         7'd35: r = mk(OP_STORE, SL_PP3, SL_PP3);
         // P times H transposed.
         7'd36: r = mk(OP_MUL,   SL_PP0, SL_H0);
         7'd37: r = mk(OP_MAC,   SL_PP1, SL_H1);
         7'd38: r = mk(OP_STORE, SL_PH0, SL_PH0);
         7'd39: r = mk(OP_MUL,   SL_PP2, SL_H0);
         7'd40: r = mk(OP_MAC,   SL_PP3, SL_H1);
         7'd41: r = mk(OP_STORE, SL_PH1, SL_PH1);
         // Innovation variance, saturated once over all three terms.
         7'd42: r = mk(OP_LOAD,  SL_R,   SL_R);
         7'd43: r = mk(OP_MAC,   SL_H0,  SL_PH0);
         7'd44: r = mk(OP_MAC,   SL_H1,  SL_PH1);
         7'd45: r = mk(OP_STORE, SL_S,   SL_S);
         // Gains.
         7'd46: r = mk(OP_DIVK,  SL_PH0, SL_K0);
         7'd47: r = mk(OP_DIVK,  SL_PH1, SL_K1);
         // Innovation.
         7'd48: r = mk(OP_MUL,   SL_H0,  SL_XP0);
         7'd49: r = mk(OP_MAC,   SL_H1,  SL_XP1);
         7'd50: r = mk(OP_STORE, SL_HX,  SL_HX);
         7'd51: r = mk(OP_LOAD,  SL_MEAS, SL_MEAS);
         7'd52: r = mk(OP_SUBV,  SL_HX,  SL_HX);
         7'd53: r = mk(OP_STORE, SL_INN, SL_INN);
         // Corrected state.
         7'd54: r = mk(OP_LOAD,  SL_XP0, SL_XP0);
         7'd55: r = mk(OP_MAC,   SL_K0,  SL_INN);
         7'd56: r = mk(OP_STORE, SL_E0,  SL_E0);
         7'd57: r = mk(OP_LOAD,  SL_XP1, SL_XP1);
         7'd58: r = mk(OP_MAC,   SL_K1,  SL_INN);
         7'd59: r = mk(OP_STORE, SL_E1,  SL_E1);
         // H times P.
         7'd60: r = mk(OP_MUL,   SL_H0,  SL_PP0);
         7'd61: r = mk(OP_MAC,   SL_H1,  SL_PP2);
         7'd62: r = mk(OP_STORE, SL_HP0, SL_HP0);
         7'd63: r = mk(OP_MUL,   SL_H0,  SL_PP1);
         7'd64: r = mk(OP_MAC,   SL_H1,  SL_PP3);
         7'd65: r = mk(OP_STORE, SL_HP1, SL_HP1);
         // Corrected covariance.
         7'd66: r = mk(OP_LOAD,  SL_PP0, SL_PP0);
         7'd67: r = mk(OP_MSUB,  SL_K0,  SL_HP0);
         7'd68: r = mk(OP_STORE, SL_C0,  SL_C0);
         7'd69: r = mk(OP_LOAD,  SL_PP1, SL_PP1);
         7'd70: r = mk(OP_MSUB,  SL_K0,  SL_HP1);
         7'd71: r = mk(OP_STORE, SL_C1,  SL_C1);
         7'd72: r = mk(OP_LOAD,  SL_PP2, SL_PP2);
         7'd73: r = mk(OP_MSUB,  SL_K1,  SL_HP0);
         7'd74: r = mk(OP_STORE, SL_C2,  SL_C2);
         7'd75: r = mk(OP_LOAD,  SL_PP3, SL_PP3);
         7'd76: r = mk(OP_MSUB,  SL_K1,  SL_HP1);
         7'd77: r = mk(OP_STORE, SL_C3,  SL_C3);
         default: r = mk(OP_END, SL_F0, SL_F0);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/kalman_filter_two_state_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Two-state Kalman filter unit
// Linear Kalman filter with two states and one scalar measurement, Q16.16.
//
// Requests arrive on the req_ channel (valid/stall): req_type 1 loads the
// estimate and clears the step count, req_type 0 runs one predict and
// correct step on req_meas. Every request gives exactly one response on the
// rsp_ channel with the estimate, the step count and a not-ready flag that
// is set for an update that comes before any init.
// For an update, the microprogram issues 38 products through one shared
// 32x32 multiplier, 38 other steps (load, add, subtract, store) and two
// gain divisions on the 48-step serial divider, then the result is loaded
// into the output register once it is free. Init requests and refused
// updates go straight to loading the output register. One request is in
// work at a time; the next is accepted once the previous result sits in
// the output register, even while that result is stalled. The response
// stays stable while rsp_stall is high. Configuration goes through the
// csr_ port, always ready; the user must write it only while idle, which the block itself does not enforce.
// Reset restores the register defaults, clears the estimate and step count,
// sets the covariance to the identity and marks the filter uninitialised.
// ----------------------------------------------------------------------------
module kalman_filter_two_state_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_type,
   input  wire logic signed [31:0] req_meas,
   input  wire logic signed [31:0] req_init_est_0,
   input  wire logic signed [31:0] req_init_est_1,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_est_0,
   output logic signed [31:0]      rsp_est_1,
   output logic [31:0]             rsp_step_count,
   output logic                    rsp_not_ready,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   kfts_pkg::cmd_type cmd;
   kfts_pkg::sts_type sts;

   // Sequencer.
   kfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Arithmetic, state and output register.
   kfts_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_meas       (req_meas),
      .req_init_est_0 (req_init_est_0),
      .req_init_est_1 (req_init_est_1),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_est_0      (rsp_est_0),
      .rsp_est_1      (rsp_est_1),
      .rsp_step_count (rsp_step_count),
      .rsp_not_ready  (rsp_not_ready)
   );

endmodule
`default_nettype wire

/* hw/rtl/kfts_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain divider
// Restoring divider forming (dividend * 65536) / divisor, truncated toward
// zero and saturated to 32 bits signed, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfts_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic signed [31:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [31:0]      quot
);

   localparam int QW = 48;
   localparam int CW = 6;
   localparam logic [CW-1:0] LAST = CW'(QW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic [QW-1:0] num_ff,  num_in;
   logic [31:0]   rem_ff,  rem_in;
   logic [31:0]   den_ff,  den_in;
   logic          neg_ff,  neg_in;
   logic          dz_ff,   dz_in;

   logic [31:0] mag_a, mag_b;
   logic [32:0] rem_sh, rem_nx;
   logic        ge;

   // Magnitudes of the operands.
   assign mag_a = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign mag_b = divisor[31]  ? (~divisor + 32'd1)  : divisor;

   // One restoring step: the quotient bit shifts in where the dividend leaves.
   assign rem_sh = {rem_ff, num_ff[QW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_nx = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      dz_in   = dz_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {mag_a, {(QW - 32){1'b0}}};
         rem_in  = '0;
         den_in  = mag_b;
         neg_in  = dividend[31] ^ divisor[31];
         dz_in   = (divisor == 32'sd0);
      end else if (busy_ff) begin
         rem_in = rem_nx[31:0];
         num_in = {num_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
   end

   // Sign, saturation and the zero-divisor case.
   always_comb begin
      if (dz_ff) begin
         quot = '0;
      end else if (!neg_ff) begin
         quot = (num_ff > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(num_ff[31:0]);
      end else begin
         quot = (num_ff > 48'h8000_0000) ? 32'sh8000_0000
                                          : signed'(~num_ff[31:0] + 32'd1);
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

/* hw/rtl/kfts_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Controller of the two-state Kalman filter unit
// Accepts requests, steps the update microprogram and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module kfts_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_type,
   input  wire kfts_pkg::sts_type sts,
   output logic                  req_stall,
   output kfts_pkg::cmd_type     cmd
);

   localparam int PW = kfts_pkg::PC_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       pc_ff, pc_in;
   logic                nr_ff, nr_in;
   kfts_pkg::instr_type instr;

   assign instr     = kfts_pkg::prog_rom(pc_ff);
   assign req_stall = (state_ff != ST_IDLE);

   // Sequencing of one request.
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      nr_in     = nr_ff;
      cmd       = '0;
      cmd.instr = instr;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               if (req_type) begin
                  cmd.init_load = 1'b1;
                  nr_in         = 1'b0;
                  state_in      = ST_DONE;
               end else if (!sts.initialized) begin
                  nr_in    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  nr_in    = 1'b0;
                  pc_in    = '0;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            unique case (instr.op)
               kfts_pkg::OP_MUL, kfts_pkg::OP_MAC, kfts_pkg::OP_MSUB: begin
                  cmd.mul_en = 1'b1;
                  state_in   = ST_ACC;
               end
               kfts_pkg::OP_DIVK: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
               kfts_pkg::OP_END: begin
                  cmd.step_inc = 1'b1;
                  state_in     = ST_DONE;
               end
               default: begin
                  cmd.exec_en = 1'b1;
                  pc_in       = pc_ff + PW'(1);
               end
            endcase
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            pc_in      = pc_ff + PW'(1);
            state_in   = ST_EXEC;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               pc_in         = pc_ff + PW'(1);
               state_in      = ST_EXEC;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_nr   = nr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         nr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         nr_ff    <= nr_in;
      end
   end

   // The program counter never runs past the final instruction.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= kfts_pkg::PROG_LAST)
      else $error("program counter past end of microprogram");

   // A finished result that finds the output register free returns to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && sts.out_free) |=> state_ff == ST_IDLE)
      else $error("result handed over without returning to idle");

   // Starting a division leaves the divider busy.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> sts.div_busy)
      else $error("divider not busy after start");

endmodule
`default_nettype wire

/* hw/rtl/kfts_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Datapath of the two-state Kalman filter unit
// Configuration registers, filter state, scratch registers, the shared
// multiplier with its accumulator, the gain divider and the output register.
// ----------------------------------------------------------------------------
module kfts_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kfts_pkg::cmd_type   cmd,
   output kfts_pkg::sts_type        sts,
   input  wire logic signed [31:0]  req_meas,
   input  wire logic signed [31:0]  req_init_est_0,
   input  wire logic signed [31:0]  req_init_est_1,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_est_0,
   output logic signed [31:0]       rsp_est_1,
   output logic [31:0]              rsp_step_count,
   output logic                     rsp_not_ready
);

   localparam int W   = kfts_pkg::DW;
   localparam int ACW = 35;
   localparam logic signed [ACW-1:0] ACC_MAX = ACW'(32'sh7FFF_FFFF);
   localparam logic signed [ACW-1:0] ACC_MIN = ACW'(32'sh8000_0000);
   localparam logic signed [63:0]    P_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0]    P_MIN   = -64'sh0000_0000_8000_0000;
   localparam logic signed [63:0]    HALF    = 64'sd32768;

   typedef struct packed {
      logic signed [W-1:0] f0, f1, f2, f3, h0, h1;
      logic [W-2:0]        q, r;
   } cfg_type;

   typedef struct packed {
      logic signed [W-1:0] e0, e1, c0, c1, c2, c3;
      logic [W-1:0]        steps;
      logic                init;
   } st_type;

   typedef struct packed {
      logic signed [W-1:0] meas, xp0, xp1, fp0, fp1, fp2, fp3, pp0, pp1, pp2, pp3;
      logic signed [W-1:0] ph0, ph1, s, k0, k1, hx, inn, hp0, hp1;
   } scr_type;

   cfg_type               cfg_ff, cfg_in;
   st_type                st_ff,  st_in;
   scr_type               scr_ff, scr_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff,  acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]   est0_ff, est0_in, est1_ff, est1_in;
   logic [W-1:0]          cnt_ff,  cnt_in;
   logic                  nr_ff,   nr_in;

   logic [kfts_pkg::NSLOT*W-1:0] slot_bus;
   logic signed [W-1:0]   val_a, val_b, mq, acc_sat, wr_data, div_q;
   logic signed [63:0]    shq;
   logic                  wr_en, div_busy, div_done, out_free;
   kfts_pkg::slot_type    wr_slot;

   // Operand slots as one flat bus.
   assign slot_bus[W*kfts_pkg::SL_F0   +: W] = cfg_ff.f0;
   assign slot_bus[W*kfts_pkg::SL_F1   +: W] = cfg_ff.f1;
   assign slot_bus[W*kfts_pkg::SL_F2   +: W] = cfg_ff.f2;
   assign slot_bus[W*kfts_pkg::SL_F3   +: W] = cfg_ff.f3;
   assign slot_bus[W*kfts_pkg::SL_H0   +: W] = cfg_ff.h0;
   assign slot_bus[W*kfts_pkg::SL_H1   +: W] = cfg_ff.h1;
   assign slot_bus[W*kfts_pkg::SL_Q    +: W] = {1'b0, cfg_ff.q};
   assign slot_bus[W*kfts_pkg::SL_R    +: W] = {1'b0, cfg_ff.r};
   assign slot_bus[W*kfts_pkg::SL_MEAS +: W] = scr_ff.meas;
   assign slot_bus[W*kfts_pkg::SL_E0   +: W] = st_ff.e0;
   assign slot_bus[W*kfts_pkg::SL_E1   +: W] = st_ff.e1;
   assign slot_bus[W*kfts_pkg::SL_C0   +: W] = st_ff.c0;
   assign slot_bus[W*kfts_pkg::SL_C1   +: W] = st_ff.c1;
   assign slot_bus[W*kfts_pkg::SL_C2   +: W] = st_ff.c2;
   assign slot_bus[W*kfts_pkg::SL_C3   +: W] = st_ff.c3;
   assign slot_bus[W*kfts_pkg::SL_XP0  +: W] = scr_ff.xp0;
   assign slot_bus[W*kfts_pkg::SL_XP1  +: W] = scr_ff.xp1;
   assign slot_bus[W*kfts_pkg::SL_FP0  +: W] = scr_ff.fp0;
   assign slot_bus[W*kfts_pkg::SL_FP1  +: W] = scr_ff.fp1;
   assign slot_bus[W*kfts_pkg::SL_FP2  +: W] = scr_ff.fp2;
   assign slot_bus[W*kfts_pkg::SL_FP3  +: W] = scr_ff.fp3;
   assign slot_bus[W*kfts_pkg::SL_PP0  +: W] = scr_ff.pp0;
   assign slot_bus[W*kfts_pkg::SL_PP1  +: W] = scr_ff.pp1;
   assign slot_bus[W*kfts_pkg::SL_PP2  +: W] = scr_ff.pp2;
   assign slot_bus[W*kfts_pkg::SL_PP3  +: W] = scr_ff.pp3;
   assign slot_bus[W*kfts_pkg::SL_PH0  +: W] = scr_ff.ph0;
   assign slot_bus[W*kfts_pkg::SL_PH1  +: W] = scr_ff.ph1;
   assign slot_bus[W*kfts_pkg::SL_S    +: W] = scr_ff.s;
   assign slot_bus[W*kfts_pkg::SL_K0   +: W] = scr_ff.k0;
   assign slot_bus[W*kfts_pkg::SL_K1   +: W] = scr_ff.k1;
   assign slot_bus[W*kfts_pkg::SL_HX   +: W] = scr_ff.hx;
   assign slot_bus[W*kfts_pkg::SL_INN  +: W] = scr_ff.inn;
   assign slot_bus[W*kfts_pkg::SL_HP0  +: W] = scr_ff.hp0;
   assign slot_bus[W*kfts_pkg::SL_HP1  +: W] = scr_ff.hp1;

   assign val_a = slot_bus[W*cmd.instr.a +: W];
   assign val_b = slot_bus[W*cmd.instr.b +: W];

   // Shared multiplier; the product is registered before rounding.
   assign prod_in = cmd.mul_en ? (64'(val_a) * 64'(val_b)) : prod_ff;

   // Round half up, floor shift by 16 and saturate to 32 bits.
   assign shq = (prod_ff + HALF) >>> 16;
   always_comb begin
      if (shq > P_MAX) begin
         mq = 32'sh7FFF_FFFF;
      end else if (shq < P_MIN) begin
         mq = 32'sh8000_0000;
      end else begin
         mq = shq[W-1:0];
      end
   end

   // Saturated view of the accumulator.
   always_comb begin
      if (acc_ff > ACC_MAX) begin
         acc_sat = 32'sh7FFF_FFFF;
      end else if (acc_ff < ACC_MIN) begin
         acc_sat = 32'sh8000_0000;
      end else begin
         acc_sat = acc_ff[W-1:0];
      end
   end

   // Accumulator update.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.exec_en) begin
         unique case (cmd.instr.op)
            kfts_pkg::OP_LOAD: acc_in = ACW'(val_a);
            kfts_pkg::OP_ADDV: acc_in = acc_ff + ACW'(val_a);
            kfts_pkg::OP_SUBV: acc_in = acc_ff - ACW'(val_a);
            default:           acc_in = acc_ff;
         endcase
      end else if (cmd.acc_en) begin
         unique case (cmd.instr.op)
            kfts_pkg::OP_MUL:  acc_in = ACW'(mq);
            kfts_pkg::OP_MAC:  acc_in = acc_ff + ACW'(mq);
            kfts_pkg::OP_MSUB: acc_in = acc_ff - ACW'(mq);
            default:           acc_in = acc_ff;
         endcase
      end
   end

   // Gain divider.
   kfts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (val_a),
      .divisor  (scr_ff.s),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_q)
   );

   // Slot write: a stored sum or a finished gain.
   always_comb begin
      wr_en   = 1'b0;
      wr_slot = cmd.instr.a;
      wr_data = acc_sat;
      if (cmd.exec_en && cmd.instr.op == kfts_pkg::OP_STORE) begin
         wr_en = 1'b1;
      end else if (cmd.div_store) begin
         wr_en   = 1'b1;
         wr_slot = cmd.instr.b;
         wr_data = div_q;
      end
   end

   // Next values of the filter state and the scratch registers.
   always_comb begin
      st_in  = st_ff;
      scr_in = scr_ff;
      if (cmd.req_load) begin
         scr_in.meas = req_meas;
      end
      if (cmd.init_load) begin
         st_in.e0    = req_init_est_0;
         st_in.e1    = req_init_est_1;
         st_in.steps = '0;
         st_in.init  = 1'b1;
      end
      if (cmd.step_inc) begin
         st_in.steps = st_ff.steps + W'(1);
      end
      if (wr_en) begin
         unique case (wr_slot)
            kfts_pkg::SL_E0:  st_in.e0   = wr_data;
            kfts_pkg::SL_E1:  st_in.e1   = wr_data;
            kfts_pkg::SL_C0:  st_in.c0   = wr_data;
            kfts_pkg::SL_C1:  st_in.c1   = wr_data;
            kfts_pkg::SL_C2:  st_in.c2   = wr_data;
            kfts_pkg::SL_C3:  st_in.c3   = wr_data;
            kfts_pkg::SL_XP0: scr_in.xp0 = wr_data;
            kfts_pkg::SL_XP1: scr_in.xp1 = wr_data;
            kfts_pkg::SL_FP0: scr_in.fp0 = wr_data;
            kfts_pkg::SL_FP1: scr_in.fp1 = wr_data;
            kfts_pkg::SL_FP2: scr_in.fp2 = wr_data;
            kfts_pkg::SL_FP3: scr_in.fp3 = wr_data;
            kfts_pkg::SL_PP0: scr_in.pp0 = wr_data;
            kfts_pkg::SL_PP1: scr_in.pp1 = wr_data;
            kfts_pkg::SL_PP2: scr_in.pp2 = wr_data;
            kfts_pkg::SL_PP3: scr_in.pp3 = wr_data;
            kfts_pkg::SL_PH0: scr_in.ph0 = wr_data;
            kfts_pkg::SL_PH1: scr_in.ph1 = wr_data;
            kfts_pkg::SL_S:   scr_in.s   = wr_data;
            kfts_pkg::SL_K0:  scr_in.k0  = wr_data;
            kfts_pkg::SL_K1:  scr_in.k1  = wr_data;
            kfts_pkg::SL_HX:  scr_in.hx  = wr_data;
            kfts_pkg::SL_INN: scr_in.inn = wr_data;
            kfts_pkg::SL_HP0: scr_in.hp0 = wr_data;
            kfts_pkg::SL_HP1: scr_in.hp1 = wr_data;
            default: ;
         endcase
      end
   end

   // Configuration writes; a zero measurement noise is taken as one LSB (2^-16 in Q16.16).
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kfts_pkg::REG_TRANS_00:   cfg_in.f0 = csr_data;
            kfts_pkg::REG_TRANS_01:   cfg_in.f1 = csr_data;
            kfts_pkg::REG_TRANS_10:   cfg_in.f2 = csr_data;
            kfts_pkg::REG_TRANS_11:   cfg_in.f3 = csr_data;
            kfts_pkg::REG_MEAS_ROW_0: cfg_in.h0 = csr_data;
            kfts_pkg::REG_MEAS_ROW_1: cfg_in.h1 = csr_data;
            kfts_pkg::REG_PROC_NOISE: cfg_in.q  = csr_data[W-2:0];
            kfts_pkg::REG_MEAS_NOISE:
               cfg_in.r = (csr_data[W-2:0] == '0) ? (W-1)'(1) : csr_data[W-2:0];
            default: ;
         endcase
      end
   end

   // Output register; it takes a new result once the old one is gone.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      est0_in      = est0_ff;
      est1_in      = est1_ff;
      cnt_in       = cnt_ff;
      nr_in        = nr_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         est0_in      = st_ff.e0;
         est1_in      = st_ff.e1;
         cnt_in       = st_ff.steps;
         nr_in        = cmd.out_nr;
      end
   end

   // Registers cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.f0    <= 32'sd65536;
         cfg_ff.f1    <= '0;
         cfg_ff.f2    <= '0;
         cfg_ff.f3    <= 32'sd65536;
         cfg_ff.h0    <= 32'sd65536;
         cfg_ff.h1    <= '0;
         cfg_ff.q     <= 31'd65536;
         cfg_ff.r     <= 31'd65536;
         st_ff.e0     <= '0;
         st_ff.e1     <= '0;
         st_ff.c0     <= 32'sd65536;
         st_ff.c1     <= '0;
         st_ff.c2     <= '0;
         st_ff.c3     <= 32'sd65536;
         st_ff.steps  <= '0;
         st_ff.init   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scr_ff  <= scr_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      est0_ff <= est0_in;
      est1_ff <= est1_in;
      cnt_ff  <= cnt_in;
      nr_ff   <= nr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_est_0      = est0_ff;
   assign rsp_est_1      = est1_ff;
   assign rsp_step_count = cnt_ff;
   assign rsp_not_ready  = nr_ff;

   assign sts.initialized = st_ff.init;
   assign sts.div_busy    = div_busy;
   assign sts.div_done    = div_done;
   assign sts.out_free    = out_free;

   // An init leaves the filter initialised with a cleared step count.
   a_init_load: assert property (@(posedge clock) disable iff (reset)
      cmd.init_load |=> (st_ff.init && st_ff.steps == '0))
      else $error("init did not set up the filter state");

   // The divider is never restarted while it is working.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("division started while divider busy");

   // A result never overwrites one that is still held by the receiver.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
